@@ rtl/core/epe_pkg.sv @@
// shared constants, types and character functions for the entity-preserving escaper
`default_nettype none

package epe_pkg;

    localparam int MAX_ENTITY_LEN = 32;
    localparam int PEND_DEPTH     = MAX_ENTITY_LEN - 1;
    localparam int CNT_W          = $clog2(MAX_ENTITY_LEN);
    localparam int PEND_IDX_W     = $clog2(PEND_DEPTH);
    localparam int LEN_W          = CNT_W;
    localparam int BYTE_W         = 8;
    localparam int MODE_W         = 2;

    localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

    // scan phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ACCEPT = 3'd1;
    localparam logic [2:0] PH_AMP    = 3'd3;
    localparam logic [2:0] PH_NAME   = 3'd4;
    localparam logic [2:0] PH_HASH   = 3'd5;
    localparam logic [2:0] PH_DEC    = 3'd6;
    localparam logic [2:0] PH_HEX    = 3'd7;

    // characters
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_LT   = 8'h3c;
    localparam logic [7:0] CH_GT   = 8'h3e;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;

    // output string codes
    typedef logic [2:0] str_code_t;
    localparam str_code_t S_NONE   = 3'd0;
    localparam str_code_t S_BYTE   = 3'd1;
    localparam str_code_t S_AMPCH  = 3'd2;
    localparam str_code_t S_LT     = 3'd3;
    localparam str_code_t S_GT     = 3'd4;
    localparam str_code_t S_QUOT   = 3'd5;
    localparam str_code_t S_AMPENT = 3'd6;

    localparam logic [47:0] STR_LT     = {16'h0, "&lt;"};
    localparam logic [47:0] STR_GT     = {16'h0, "&gt;"};
    localparam logic [47:0] STR_QUOT   = "&quot;";
    localparam logic [47:0] STR_AMPENT = {8'h0, "&amp;"};

    // emission segments, in output order
    localparam int NUM_SEG = 4;
    localparam int SEG_W   = 2;
    localparam int SEL_W   = SEG_W + 1;
    localparam logic [SEG_W-1:0] SEG_LEAD  = 2'd0;
    localparam logic [SEG_W-1:0] SEG_PEND  = 2'd1;
    localparam logic [SEG_W-1:0] SEG_TAIL  = 2'd2;
    localparam logic [SEG_W-1:0] SEG_FLUSH = 2'd3;

    typedef logic [NUM_SEG-1:0][LEN_W-1:0] seg_len_t;

    typedef struct packed {
        logic             found;
        logic [SEG_W-1:0] seg;
    } seg_pick_t;

    typedef struct packed {
        logic             accept;
        logic             emit;
        logic [SEG_W-1:0] seg;
        logic [LEN_W-1:0] idx;
        logic             run_last;
    } ctl_cmd_t;

    typedef struct packed {
        seg_len_t cur_len;
        seg_len_t next_len;
        logic     out_free;
    } dp_status_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    function automatic logic is_hexletter(logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // dfa step, PH_IDLE means the scan fails
    function automatic logic [2:0] next_phase(logic [2:0] ph, logic [7:0] c);
        logic [2:0] nx;
        nx = PH_IDLE;
        unique case (ph)
            PH_AMP:
            begin
                if (c == CH_HASH) nx = PH_HASH;
                else if (is_letter(c) || is_digit(c)) nx = PH_NAME;
            end
            PH_NAME:
            begin
                if (is_letter(c) || is_digit(c)) nx = PH_NAME;
                else if (c == CH_SEMI) nx = PH_ACCEPT;
            end
            PH_HASH:
            begin
                if (c == CH_X) nx = PH_HEX;
                else if (is_digit(c)) nx = PH_DEC;
            end
            PH_DEC:
            begin
                if (is_digit(c)) nx = PH_DEC;
                else if (c == CH_SEMI) nx = PH_ACCEPT;
            end
            PH_HEX:
            begin
                if (is_digit(c) || is_hexletter(c)) nx = PH_HEX;
                else if (c == CH_SEMI) nx = PH_ACCEPT;
            end
            default: nx = PH_IDLE;
        endcase
        return nx;
    endfunction

    function automatic logic fresh_opens(logic [MODE_W-1:0] mode, logic [7:0] b);
        return (mode != MODE_PASS) && mode[0] && (b == CH_AMP);
    endfunction

    function automatic str_code_t fresh_code(logic [MODE_W-1:0] mode, logic [7:0] b);
        str_code_t code;
        code = S_BYTE;
        if (mode != MODE_PASS)
        begin
            if (b == CH_LT) code = S_LT;
            else if (b == CH_GT) code = S_GT;
            else if (b == CH_QUOT) code = S_QUOT;
            else if (b == CH_AMP) code = mode[0] ? S_NONE : S_AMPENT;
        end
        return code;
    endfunction

    function automatic logic [LEN_W-1:0] str_len(str_code_t code);
        int n;
        unique case (code)
            S_BYTE, S_AMPCH: n = 1;
            S_LT, S_GT:      n = 4;
            S_QUOT:          n = 6;
            S_AMPENT:        n = 5;
            default:         n = 0;
        endcase
        return LEN_W'(n);
    endfunction

    function automatic logic [7:0] str_char(str_code_t code, logic [2:0] idx, logic [7:0] b);
        logic [47:0] s;
        logic [2:0]  last;
        logic [2:0]  sh;
        s    = '0;
        last = '0;
        unique case (code)
            S_LT:     begin s = STR_LT;     last = 3'd3; end
            S_GT:     begin s = STR_GT;     last = 3'd3; end
            S_QUOT:   begin s = STR_QUOT;   last = 3'd5; end
            S_AMPENT: begin s = STR_AMPENT; last = 3'd4; end
            default:  begin s = '0;         last = '0;   end
        endcase
        sh = last - idx;
        if (code == S_BYTE) return b;
        if (code == S_AMPCH) return CH_AMP;
        return s[{sh, 3'b000} +: 8];
    endfunction

    // lowest non-empty segment at or after from
    function automatic seg_pick_t first_seg(seg_len_t lens, logic [SEL_W-1:0] from);
        seg_pick_t p;
        p.found = 1'b0;
        p.seg   = '0;
        for (int i = NUM_SEG - 1; i >= 0; i--)
        begin
            if ((SEL_W'(i) >= from) && (lens[i] != '0))
            begin
                p.found = 1'b1;
                p.seg   = SEG_W'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/epe_ifs.sv @@
// valid/ready channel interfaces for raw text beats and escaped text beats
`default_nettype none

interface epe_in_if;
    import epe_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_end;
    modport source (output valid, output in_byte, output in_end, input ready);
    modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

interface epe_out_if;
    import epe_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_run_last;
    logic              out_stream_end;
    modport source (output valid, output out_byte, output out_run_last,
                    output out_stream_end, input ready);
    modport sink   (input valid, input out_byte, input out_run_last,
                    input out_stream_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/epe_ctrl.sv @@
// emission sequencer: walks the segments of one beat's output and gates input
`default_nettype none

module epe_ctrl (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire epe_pkg::dp_status_t  status,
    output epe_pkg::ctl_cmd_t         cmd
);
    import epe_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             state_reg, state_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [LEN_W-1:0] idx_reg, idx_next;

    logic [LEN_W-1:0] cur_len;
    logic             last_in_seg;
    seg_pick_t        after_pick;
    seg_pick_t        start_pick;
    logic             emit;
    logic             fin;
    logic             accept;

    always_comb
    begin
        cur_len     = status.cur_len[seg_reg];
        last_in_seg = (idx_reg == (cur_len - 1'b1));
        after_pick  = first_seg(status.cur_len, {1'b0, seg_reg} + 1'b1);
        start_pick  = first_seg(status.next_len, '0);
        emit        = (state_reg == ST_EMIT) && status.out_free;
        fin         = emit && last_in_seg && !after_pick.found;
        in_ready    = (state_reg == ST_IDLE) || fin;
        accept      = in_valid && in_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        idx_next   = idx_reg;
        priority if (accept)
        begin
            state_next = start_pick.found ? ST_EMIT : ST_IDLE;
            seg_next   = start_pick.seg;
            idx_next   = '0;
        end
        else if (emit)
        begin
            if (last_in_seg)
            begin
                if (after_pick.found)
                begin
                    seg_next = after_pick.seg;
                    idx_next = '0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else
        begin
            // waiting for a beat or for the receiver
            state_next = state_reg;
        end
    end

    always_comb
    begin
        cmd.accept   = accept;
        cmd.emit     = emit;
        cmd.seg      = seg_reg;
        cmd.idx      = idx_reg;
        cmd.run_last = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seg_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/epe_datapath.sv @@
// scan dfa, pending byte store, per-beat output plan and output register
`default_nettype none

module epe_datapath (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire [epe_pkg::BYTE_W-1:0]    in_byte,
    input  wire                          in_end,
    input  wire                          cfg_wr_en,
    input  wire [epe_pkg::MODE_W-1:0]    cfg_wr_data,
    input  wire epe_pkg::ctl_cmd_t       cmd,
    output epe_pkg::dp_status_t          status,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [epe_pkg::BYTE_W-1:0]   out_byte,
    output logic                         out_run_last,
    output logic                         out_stream_end
);
    import epe_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [2:0]        phase_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [BYTE_W-1:0] pend_mem [PEND_DEPTH];

    str_code_t         lead_reg, tail_reg, flush_reg;
    seg_len_t          len_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              end_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;
    logic              stream_end_reg;

    // plan for the beat at the input
    logic [2:0]        nx;
    str_code_t         fcode;
    logic              fopen;
    logic              at_limit;
    logic [CNT_W-1:0]  count_inc;
    str_code_t         lead_next, tail_next, flush_next;
    logic [LEN_W-1:0]  npend_next;
    logic              hold;
    logic [2:0]        phase_next;
    logic [CNT_W-1:0]  count_next;
    seg_len_t          len_next;
    logic [BYTE_W-1:0] emit_byte;

    always_comb
    begin
        nx         = next_phase(phase_reg, in_byte);
        fcode      = fresh_code(mode_reg, in_byte);
        fopen      = fresh_opens(mode_reg, in_byte);
        at_limit   = (count_reg >= CNT_W'(MAX_ENTITY_LEN - 2));
        count_inc  = count_reg + 1'b1;
        lead_next  = S_NONE;
        tail_next  = S_NONE;
        flush_next = S_NONE;
        npend_next = '0;
        hold       = 1'b0;
        phase_next = PH_IDLE;
        count_next = '0;
        if (phase_reg != PH_IDLE)
        begin
            if (nx == PH_ACCEPT)
            begin
                lead_next  = S_AMPCH;
                npend_next = count_reg;
                tail_next  = S_BYTE;
            end
            else if (nx == PH_IDLE)
            begin
                // failed scan: &amp;, held bytes, then this byte afresh
                lead_next  = S_AMPENT;
                npend_next = count_reg;
                tail_next  = fcode;
                if (fopen)
                begin
                    if (in_end) flush_next = S_AMPENT;
                    else phase_next = PH_AMP;
                end
            end
            else
            begin
                hold = 1'b1;
                if (at_limit || in_end)
                begin
                    lead_next  = S_AMPENT;
                    npend_next = count_inc;
                end
                else
                begin
                    phase_next = nx;
                    count_next = count_inc;
                end
            end
        end
        else
        begin
            tail_next = fcode;
            if (fopen)
            begin
                if (in_end) flush_next = S_AMPENT;
                else phase_next = PH_AMP;
            end
        end
        len_next[SEG_LEAD]  = str_len(lead_next);
        len_next[SEG_PEND]  = npend_next;
        len_next[SEG_TAIL]  = str_len(tail_next);
        len_next[SEG_FLUSH] = str_len(flush_next);
    end

    always_comb
    begin
        unique case (cmd.seg)
            SEG_LEAD:  emit_byte = str_char(lead_reg, cmd.idx[2:0], byte_reg);
            SEG_PEND:  emit_byte = pend_mem[cmd.idx[PEND_IDX_W-1:0]];
            SEG_TAIL:  emit_byte = str_char(tail_reg, cmd.idx[2:0], byte_reg);
            SEG_FLUSH: emit_byte = str_char(flush_reg, cmd.idx[2:0], byte_reg);
        endcase
    end

    always_comb
    begin
        status.cur_len  = len_reg;
        status.next_len = len_next;
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_run_last   = run_last_reg;
    assign out_stream_end = stream_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                len_reg   <= len_next;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            lead_reg  <= lead_next;
            tail_reg  <= tail_next;
            flush_reg <= flush_next;
            byte_reg  <= in_byte;
            end_reg   <= in_end;
            if (hold)
                pend_mem[count_reg[PEND_IDX_W-1:0]] <= in_byte;
        end
        if (cmd.emit)
        begin
            out_byte_reg   <= emit_byte;
            run_last_reg   <= cmd.run_last;
            stream_end_reg <= cmd.run_last && end_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/entity_preserving_html_escaper_core.sv @@
// top level of the html escaper that keeps existing entities intact
//
// raw carries one text byte per beat plus in_end on the last byte of a text.
// escaped carries one output byte per beat; out_run_last marks the final byte
// caused by one raw beat, out_stream_end the final byte of the whole text.
// cfg_wr_en/cfg_wr_data write escape_mode (0 pass, 1 escape but keep
// entities, 2 escape all, 3 same as 1); write it only while the block is idle.
// timing: a raw beat that causes output bytes occupies the sequencer after
// its acceptance until its last byte is emitted, and the next raw beat is taken
// in the cycle of the last emission, so plain text runs at one byte per cycle
// while the receiver does not stall. the rate is set by the single output byte
// register, which is loaded at most once per cycle.
// an accepted beat's first output byte appears once the sequencer emits it.
// in mode 1 a '&' and the bytes after it are held until the entity closes,
// fails, hits the length limit or the text ends, then all come out in one run.
// reset: mode returns to 2, any open entity scan is dropped, output empties.
// receiver stall: the output register holds its beat, the sequencer waits,
// and raw.ready stays low until the last byte of the current run is loaded.
`default_nettype none

module entity_preserving_html_escaper_core (
    input  wire                        clk,
    input  wire                        rst_n,
    epe_in_if.sink                     raw,
    epe_out_if.source                  escaped,
    input  wire                        cfg_wr_en,
    input  wire [epe_pkg::MODE_W-1:0]  cfg_wr_data
);
    import epe_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;
    logic       in_ready;

    // sequencer: decides when to take a raw beat and which byte to emit
    epe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (raw.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: entity dfa, held bytes, plan of the run and output register
    epe_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_byte        (raw.in_byte),
        .in_end         (raw.in_end),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (escaped.valid),
        .out_ready      (escaped.ready),
        .out_byte       (escaped.out_byte),
        .out_run_last   (escaped.out_run_last),
        .out_stream_end (escaped.out_stream_end)
    );

    assign raw.ready = in_ready;

endmodule

`default_nettype wire

@@ rtl/core/epe_checker.sv @@
// port-level checks for the escaper top level and the bind that attaches them
`default_nettype none

module epe_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       out_valid,
    input wire       out_ready,
    input wire [7:0] out_byte,
    input wire       out_run_last,
    input wire       out_stream_end
);

    // stalled output beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(out_run_last) && $stable(out_stream_end))
        else $error("stalled output beat changed");

    // end of text only on the last byte of a run
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stream_end |-> out_run_last)
        else $error("stream end without run last");

    // no new raw beat while a run is stuck mid-way
    a_no_take_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !out_run_last |-> !(in_valid && in_ready))
        else $error("raw beat taken during an unfinished run");

endmodule

bind entity_preserving_html_escaper_core epe_checker u_epe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (raw.valid),
    .in_ready       (raw.ready),
    .out_valid      (escaped.valid),
    .out_ready      (escaped.ready),
    .out_byte       (escaped.out_byte),
    .out_run_last   (escaped.out_run_last),
    .out_stream_end (escaped.out_stream_end)
);

`default_nettype wire
